### rtl/x86_instruction_length_decoder_top_defines.svh
// ----------------------------------------------------------------------------
// x86 length decoder assertion macros
// Concurrent check helpers, compiled away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef X86_INSTRUCTION_LENGTH_DECODER_TOP_DEFINES_SVH
`define X86_INSTRUCTION_LENGTH_DECODER_TOP_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define XILD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("xild check failed");
// next-cycle implication
`define XILD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("xild check failed");
`else
`define XILD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define XILD_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

### rtl/xild_pkg.sv
// ----------------------------------------------------------------------------
// xild_pkg
// Constants and opcode classification functions for the x86 length decoder.
// ----------------------------------------------------------------------------
package xild_pkg;

  // byte counter
  localparam int         CNT_W          = 5;
  localparam int         MAX_INSN_BYTES = 15;
  localparam logic [4:0] CNT_MAX        = 5'd31;
  localparam logic [3:0] LEN_SAT        = 4'd15;

  // special bytes
  localparam logic [7:0] BRK_BYTE    = 8'hCC;
  localparam logic [7:0] OPSIZE_PFX  = 8'h66;
  localparam logic [7:0] ESC_0F      = 8'h0F;
  localparam logic [7:0] FPU_ESC     = 8'hD8;
  localparam logic [7:0] FPU_ESC_MSK = 8'hF8;
  localparam logic [7:0] NO_MODRM    = 8'hFF;

  // modrm fields
  localparam logic [1:0] MOD_MEM0   = 2'b00;
  localparam logic [1:0] MOD_DISP8  = 2'b01;
  localparam logic [1:0] MOD_DISP32 = 2'b10;
  localparam logic [1:0] MOD_REG    = 2'b11;
  localparam logic [2:0] RM_SIB     = 3'b100;
  localparam logic [2:0] RM_NOBASE  = 3'b101;

  // operand sizes
  localparam logic [2:0] OSZ_LONG  = 3'd4;
  localparam logic [2:0] OSZ_SHORT = 3'd2;
  localparam logic [2:0] OSZ_NONE  = 3'd0;

  // legacy prefix bytes
  function automatic logic is_prefix(input logic [7:0] b);
    return (b == 8'hF0) || (b == 8'hF2) || (b == 8'hF3) ||
           ((b & 8'hFC) == 8'h64) || ((b & 8'hE7) == 8'h26);
  endfunction

  // one-byte map opcodes followed by modrm
  function automatic logic one_byte_has_modrm(input logic [7:0] op);
    return ((op & 8'hC4) == 8'h00) ||
           (((op & 8'hF4) == 8'h60) &&
            (((op & 8'h0A) == 8'h02) || ((op & 8'h09) == 8'h09))) ||
           ((op & 8'hF0) == 8'h80) ||
           (((op & 8'hF8) == 8'hC0) && ((op & 8'h0E) != 8'h02)) ||
           ((op & 8'hFC) == 8'hD0) ||
           ((op & 8'hF6) == 8'hF6);
  endfunction

  // two-byte map opcodes followed by modrm
  function automatic logic two_byte_has_modrm(input logic [7:0] op);
    logic none;
    none = ((op[7:4] == 4'h0) && (op[3:0] >= 4'h4) && ((op & 8'h0D) != 8'h0D)) ||
           (op[7:4] == 4'h3) ||
           (op == 8'h77) ||
           (op[7:4] == 4'h8) ||
           ((op[7:4] == 4'hA) && (op[2:0] <= 3'd2)) ||
           ((op & 8'hF8) == 8'hC8);
    return !none;
  endfunction

  // immediate byte count for an opcode and its modrm
  function automatic logic [2:0] imm_count(input logic [7:0] op, input logic [7:0] m,
                                           input logic short_ops, input logic fpu,
                                           input logic esc);
    logic [2:0] osz;
    logic [2:0] cnt;
    osz = short_ops ? OSZ_SHORT : OSZ_LONG;
    cnt = 3'd0;
    if (fpu) begin
      cnt = 3'd0;
    end else if (!esc) begin
      if (((op & 8'hC7) == 8'h04) || ((op & 8'hFE) == 8'h6A) ||
          ((op & 8'hF0) == 8'h70) || (op == 8'h80) || (op == 8'h83) ||
          ((op & 8'hFD) == 8'hA0) || (op == 8'hA8) ||
          ((op & 8'hF8) == 8'hB0) || ((op & 8'hFE) == 8'hC0) ||
          (op == 8'hC6) || (op == 8'hCD) || ((op & 8'hFE) == 8'hD4) ||
          ((op & 8'hF8) == 8'hE0) || (op == 8'hEB) ||
          ((op == 8'hF6) && ((m & 8'h30) == 8'h00))) begin
        cnt = 3'd1;
      end else if ((op & 8'hF7) == 8'hC2) begin
        cnt = 3'd2;
      end else if (((op & 8'hFC) == 8'h80) || ((op & 8'hC7) == 8'h05) ||
                   ((op & 8'hF8) == 8'hB8) || ((op & 8'hFE) == 8'hE8) ||
                   ((op & 8'hFE) == 8'h68) || ((op & 8'hFC) == 8'hA0) ||
                   ((op & 8'hEE) == 8'hA8) || (op == 8'hC7) ||
                   ((op == 8'hF7) && ((m & 8'h30) == 8'h00))) begin
        cnt = osz;
      end
    end else begin
      if ((op == 8'hBA) || (op == 8'h0F) || ((op & 8'hFC) == 8'h70) ||
          ((op & 8'hF7) == 8'hA4) || (op == 8'hC2) || (op == 8'hC4) ||
          (op == 8'hC5) || (op == 8'hC6)) begin
        cnt = 3'd1;
      end else if (op[7:4] == 4'h8) begin
        cnt = osz;
      end
    end
    return cnt;
  endfunction

endpackage

### rtl/x86_instruction_length_decoder_top.sv
// ----------------------------------------------------------------------------
// x86_instruction_length_decoder_top
// Byte-serial length decoder for 32-bit x86 code.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / code_byte) takes one byte of the
//   instruction stream per transfer. Output channel (out_valid / out_stall and
//   the result fields) gives one result per finished instruction, in the
//   cycle after the transfer of its last byte. A 0xCC at the start of an
//   instruction gives a breakpoint result of length zero by itself.
//   Throughput is one byte per cycle while in_stall is low: each byte is decoded
//   by short combinational logic between the decode state registers and the
//   result register.
//   When the receiver stalls, the held result stays in the result register
//   and in_stall is high while a result is waiting and stalled; every byte,
//   whether or not it finishes an instruction, waits until the result
//   register is free or drains in the same cycle.
//   Synchronous reset returns the decoder to the start of an instruction and
//   drops any pending result.
// ----------------------------------------------------------------------------
`include "x86_instruction_length_decoder_top_defines.svh"

module x86_instruction_length_decoder_top
  import xild_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] code_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] insn_length,
  output logic [7:0] main_opcode,
  output logic [2:0] operand_bytes,
  output logic       two_byte_map,
  output logic       breakpoint_seen,
  output logic       length_overflow
);

  typedef enum logic [2:0] {
    PH_START,
    PH_PREFIX,
    PH_AFTER_FPU,
    PH_OPCODE,
    PH_MODRM,
    PH_SIB,
    PH_DISP,
    PH_IMM
  } phase_t;

  // decode state
  phase_t           phase, phase_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic             short_ops, short_ops_next;
  logic             fpu_seen, fpu_seen_next;
  logic             esc_seen, esc_seen_next;
  logic [7:0]       held_opcode, held_opcode_next;
  logic [7:0]       held_modrm, held_modrm_next;
  logic [2:0]       disp_left, disp_left_next;
  logic [2:0]       imm_left, imm_left_next;

  logic accept;
  logic emit;
  logic emit_brk;

  // result register is free or drains this cycle
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  // next decode state for the byte on the input
  always_comb begin
    logic       take_op;
    logic       run_modrm;
    logic       adv;
    logic [7:0] m_sel;
    take_op          = 1'b0;
    run_modrm        = 1'b0;
    adv              = 1'b0;
    m_sel            = held_modrm;
    emit             = 1'b0;
    emit_brk         = 1'b0;
    phase_next       = phase;
    short_ops_next   = short_ops;
    fpu_seen_next    = fpu_seen;
    esc_seen_next    = esc_seen;
    held_opcode_next = held_opcode;
    held_modrm_next  = held_modrm;
    disp_left_next   = disp_left;
    imm_left_next    = imm_left;
    byte_count_next  = (byte_count < CNT_MAX) ? byte_count + 1'b1 : byte_count;

    if (phase == PH_START && code_byte == BRK_BYTE) begin
      emit     = 1'b1;
      emit_brk = 1'b1;
    end else begin
      unique case (phase)
        PH_START, PH_PREFIX: begin
          if (is_prefix(code_byte)) begin
            if (code_byte == OPSIZE_PFX) short_ops_next = 1'b1;
            phase_next = PH_PREFIX;
          end else if ((code_byte & FPU_ESC_MSK) == FPU_ESC) begin
            fpu_seen_next = 1'b1;
            phase_next    = PH_AFTER_FPU;
          end else if (code_byte == ESC_0F) begin
            esc_seen_next = 1'b1;
            phase_next    = PH_OPCODE;
          end else begin
            take_op = 1'b1;
          end
        end
        PH_AFTER_FPU: begin
          if (code_byte == ESC_0F) begin
            esc_seen_next = 1'b1;
            phase_next    = PH_OPCODE;
          end else begin
            take_op = 1'b1;
          end
        end
        PH_OPCODE: take_op = 1'b1;
        PH_MODRM: begin
          run_modrm = 1'b1;
          m_sel     = code_byte;
        end
        PH_SIB: begin
          if (held_modrm[7:6] == MOD_DISP32 ||
              (held_modrm[7:6] == MOD_MEM0 && code_byte[2:0] == RM_NOBASE))
            disp_left_next = 3'd4;
          else if (held_modrm[7:6] == MOD_DISP8)
            disp_left_next = 3'd1;
          else
            disp_left_next = 3'd0;
          adv = 1'b1;
        end
        PH_DISP: begin
          if (disp_left != 3'd0) disp_left_next = disp_left - 3'd1;
          adv = 1'b1;
        end
        PH_IMM: begin
          if (imm_left != 3'd0) imm_left_next = imm_left - 3'd1;
          adv = 1'b1;
        end
        default: phase_next = PH_START;
      endcase

      // opcode byte
      if (take_op) begin
        held_opcode_next = code_byte;
        if (fpu_seen) begin
          run_modrm = 1'b1;
          m_sel     = (code_byte[7:6] != MOD_REG) ? code_byte : NO_MODRM;
        end else if (esc_seen ? two_byte_has_modrm(code_byte)
                              : one_byte_has_modrm(code_byte)) begin
          phase_next = PH_MODRM;
        end else begin
          run_modrm = 1'b1;
          m_sel     = NO_MODRM;
        end
      end

      // modrm decode: sib, displacement and immediate sizes
      if (run_modrm) begin
        held_modrm_next = m_sel;
        imm_left_next   = imm_count(held_opcode_next, m_sel, short_ops, fpu_seen, esc_seen);
        if (m_sel[2:0] == RM_SIB && m_sel[7:6] != MOD_REG) begin
          phase_next = PH_SIB;
        end else begin
          if ((m_sel[7:6] == MOD_MEM0 && m_sel[2:0] == RM_NOBASE) ||
              m_sel[7:6] == MOD_DISP32)
            disp_left_next = 3'd4;
          else if (m_sel[7:6] == MOD_DISP8)
            disp_left_next = 3'd1;
          else
            disp_left_next = 3'd0;
          adv = 1'b1;
        end
      end

      // move on to trailing bytes or finish
      if (adv) begin
        if (disp_left_next != 3'd0)
          phase_next = PH_DISP;
        else if (imm_left_next != 3'd0)
          phase_next = PH_IMM;
        else
          emit = 1'b1;
      end
    end
  end

  // decode state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_START;
      byte_count  <= '0;
      short_ops   <= 1'b0;
      fpu_seen    <= 1'b0;
      esc_seen    <= 1'b0;
      held_opcode <= 8'h00;
      held_modrm  <= NO_MODRM;
      disp_left   <= 3'd0;
      imm_left    <= 3'd0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (accept) begin
        if (emit) begin
          out_valid <= 1'b1;
          if (emit_brk) begin
            insn_length     <= 4'd0;
            main_opcode     <= 8'h00;
            operand_bytes   <= OSZ_NONE;
            two_byte_map    <= 1'b0;
            breakpoint_seen <= 1'b1;
            length_overflow <= 1'b0;
          end else begin
            insn_length     <= (byte_count_next > CNT_W'(LEN_SAT)) ? LEN_SAT
                                                                   : byte_count_next[3:0];
            main_opcode     <= held_opcode_next;
            operand_bytes   <= short_ops_next ? OSZ_SHORT : OSZ_LONG;
            two_byte_map    <= esc_seen_next;
            breakpoint_seen <= 1'b0;
            length_overflow <= (byte_count_next > CNT_W'(MAX_INSN_BYTES));
          end
          phase       <= PH_START;
          byte_count  <= '0;
          short_ops   <= 1'b0;
          fpu_seen    <= 1'b0;
          esc_seen    <= 1'b0;
          held_opcode <= 8'h00;
          held_modrm  <= NO_MODRM;
          disp_left   <= 3'd0;
          imm_left    <= 3'd0;
        end else begin
          phase       <= phase_next;
          byte_count  <= byte_count_next;
          short_ops   <= short_ops_next;
          fpu_seen    <= fpu_seen_next;
          esc_seen    <= esc_seen_next;
          held_opcode <= held_opcode_next;
          held_modrm  <= held_modrm_next;
          disp_left   <= disp_left_next;
          imm_left    <= imm_left_next;
        end
      end
    end
  end

  // checks
  `XILD_ASSERT_NXT(a_emit_restarts, clk, rst, accept && emit,
                   phase == PH_START && byte_count == '0)
  `XILD_ASSERT_IMP(a_brk_fields, clk, rst, out_valid && breakpoint_seen,
                   insn_length == 4'd0 && main_opcode == 8'h00 && operand_bytes == OSZ_NONE)
  `XILD_ASSERT_IMP(a_osz_legal, clk, rst, out_valid && !breakpoint_seen,
                   operand_bytes == OSZ_SHORT || operand_bytes == OSZ_LONG)
  `XILD_ASSERT_IMP(a_ovf_saturates, clk, rst, out_valid && length_overflow,
                   insn_length == LEN_SAT)

endmodule
